/* rtl/sip_pkg.sv */
`timescale 1ns / 1ps
// Shared definitions for the segment intersection parameter pipeline.
// No dependencies; imported by every module of the block.
package sip_pkg;

  // Default geometry: coordinate width and fraction bits of alpha/beta.
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;

  // Width of the minimum denominator register.
  localparam int MIN_DEN_BITS = 30;

  // Minimum denominator value after reset.
  localparam logic [MIN_DEN_BITS-1:0] MIN_DEN_RESET = MIN_DEN_BITS'(1);

  // Control that travels with each transaction down the pipeline.
  typedef struct packed {
    logic valid;
    logic hit;
  } sip_ctl_t;

endpackage

/* rtl/segment_intersection_params_top.sv */
`timescale 1ns / 1ps
// Top level of the parametric segment intersection pipeline.
// Depends on sip_pkg, sip_cross, sip_qual, sip_div and sip_out.

// Computes where segment AB meets segment CD: alpha along AB and beta along
// CD as unsigned fractions with FRAC_BITS fraction bits (1.0 is 2^FRAC_BITS),
// truncated toward zero, plus a hit flag. A hit needs an absolute cross
// product of at least cfg_wr_data's last written value (zero behaves as one)
// and both parameters within [0, 1], endpoints included; on a miss all three
// result fields are zero. One transaction is accepted per clock while
// in_stall is low. The divider spends one pipeline stage per quotient bit
// (FRAC_BITS + 1 stages); it follows three cross-product stages and two
// qualification stages and precedes the output register. When the output
// is stalled a one-entry skid buffer catches the next result, and in_stall
// rises as soon as it fills; the whole pipeline holds until the buffer
// drains. Write the minimum register only while the block is empty; it
// resets to one.
module segment_intersection_params_top #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration
  input  logic                             cfg_wr_en,
  input  logic [sip_pkg::MIN_DEN_BITS-1:0] cfg_wr_data,
  // input channel
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [COORD_BITS-1:0]     in_first_start_x,
  input  logic signed [COORD_BITS-1:0]     in_first_start_y,
  input  logic signed [COORD_BITS-1:0]     in_first_end_x,
  input  logic signed [COORD_BITS-1:0]     in_first_end_y,
  input  logic signed [COORD_BITS-1:0]     in_second_start_x,
  input  logic signed [COORD_BITS-1:0]     in_second_start_y,
  input  logic signed [COORD_BITS-1:0]     in_second_end_x,
  input  logic signed [COORD_BITS-1:0]     in_second_end_y,
  // result channel
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_hit,
  output logic [FRAC_BITS:0]               out_alpha,
  output logic [FRAC_BITS:0]               out_beta
);
  import sip_pkg::*;

  localparam int SW = 2 * COORD_BITS + 3;  // width of the cross-product sums

  logic [MIN_DEN_BITS-1:0] min_den_r;
  logic                    pipe_en;

  logic                 cross_valid;
  logic signed [SW-1:0] cross_den, cross_na, cross_nb;

  sip_ctl_t             qual_ctl, div_ctl;
  logic [SW-1:0]        qual_den, qual_na, qual_nb;
  logic [FRAC_BITS:0]   quo_a, quo_b;

  // Hold the minimum absolute denominator.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_den_r <= MIN_DEN_RESET;
    end else if (cfg_wr_en) begin
      min_den_r <= cfg_wr_data;
    end
  end

  // The stages before the output register advance together unless the skid buffer is occupied.
  assign in_stall = !pipe_en;

  sip_cross #(
    .COORD_BITS(COORD_BITS)
  ) u_cross (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (in_valid),
    .ax        (in_first_start_x),
    .ay        (in_first_start_y),
    .bx        (in_first_end_x),
    .by        (in_first_end_y),
    .cx        (in_second_start_x),
    .cy        (in_second_start_y),
    .dx        (in_second_end_x),
    .dy        (in_second_end_y),
    .out_valid (cross_valid),
    .den       (cross_den),
    .num_a     (cross_na),
    .num_b     (cross_nb)
  );

  sip_qual #(
    .SUM_BITS(SW)
  ) u_qual (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (pipe_en),
    .in_valid  (cross_valid),
    .den       (cross_den),
    .num_a     (cross_na),
    .num_b     (cross_nb),
    .min_den   (min_den_r),
    .out_ctl   (qual_ctl),
    .out_den   (qual_den),
    .out_num_a (qual_na),
    .out_num_b (qual_nb)
  );

  sip_div #(
    .WIDTH    (SW),
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (pipe_en),
    .in_ctl  (qual_ctl),
    .den     (qual_den),
    .num_a   (qual_na),
    .num_b   (qual_nb),
    .out_ctl (div_ctl),
    .quo_a   (quo_a),
    .quo_b   (quo_b)
  );

  sip_out #(
    .FRAC_BITS(FRAC_BITS)
  ) u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ctl    (div_ctl),
    .quo_a     (quo_a),
    .quo_b     (quo_b),
    .pipe_en   (pipe_en),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_hit   (out_hit),
    .out_alpha (out_alpha),
    .out_beta  (out_beta)
  );

  // A full skid buffer means a result is already waiting at the output.
  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |-> out_valid)
    else $error("skid buffer holds a transaction while the output is empty");

  // A miss carries zero fractions.
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_alpha == '0 && out_beta == '0))
    else $error("miss result with nonzero alpha or beta");

  // A hit never reports a fraction above one.
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |->
      (out_alpha <= ((FRAC_BITS+1)'(1) << FRAC_BITS) &&
       out_beta  <= ((FRAC_BITS+1)'(1) << FRAC_BITS)))
    else $error("hit result with a fraction above one");

  // The pipeline only freezes the cycle after a stalled output.
  a_freeze_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pipe_en) |-> $past(out_valid && out_stall))
    else $error("pipeline froze without a stalled output");

endmodule

/* rtl/sip_cross.sv */
`timescale 1ns / 1ps
// Cross-product front end: endpoint differences, six products, three sums.
// Depends on sip_pkg.
module sip_cross #(
  parameter int COORD_BITS = sip_pkg::COORD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic signed [COORD_BITS-1:0]  ax,
  input  logic signed [COORD_BITS-1:0]  ay,
  input  logic signed [COORD_BITS-1:0]  bx,
  input  logic signed [COORD_BITS-1:0]  by,
  input  logic signed [COORD_BITS-1:0]  cx,
  input  logic signed [COORD_BITS-1:0]  cy,
  input  logic signed [COORD_BITS-1:0]  dx,
  input  logic signed [COORD_BITS-1:0]  dy,
  output logic                          out_valid,
  output logic signed [2*COORD_BITS+2:0] den,
  output logic signed [2*COORD_BITS+2:0] num_a,
  output logic signed [2*COORD_BITS+2:0] num_b
);
  import sip_pkg::*;

  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 1;

  logic signed [DW-1:0] abx_r, aby_r, cdx_r, cdy_r, acx_r, acy_r;
  logic signed [DW-1:0] abx_nxt, aby_nxt, cdx_nxt, cdy_nxt, acx_nxt, acy_nxt;
  logic signed [PW-1:0] p_d0_r, p_d1_r, p_a0_r, p_a1_r, p_b0_r, p_b1_r;
  logic signed [SW-1:0] den_r, na_r, nb_r;
  logic signed [SW-1:0] den_nxt, na_nxt, nb_nxt;
  logic                 v1_r, v2_r, v3_r;

  // Stage 1: differences, one bit wider than the coordinates.
  always_comb begin
    abx_nxt = $signed({bx[COORD_BITS-1], bx}) - $signed({ax[COORD_BITS-1], ax});
    aby_nxt = $signed({by[COORD_BITS-1], by}) - $signed({ay[COORD_BITS-1], ay});
    cdx_nxt = $signed({dx[COORD_BITS-1], dx}) - $signed({cx[COORD_BITS-1], cx});
    cdy_nxt = $signed({dy[COORD_BITS-1], dy}) - $signed({cy[COORD_BITS-1], cy});
    acx_nxt = $signed({ax[COORD_BITS-1], ax}) - $signed({cx[COORD_BITS-1], cx});
    acy_nxt = $signed({ay[COORD_BITS-1], ay}) - $signed({cy[COORD_BITS-1], cy});
  end

  // Stage 3: differences of the product pairs.
  always_comb begin
    den_nxt = $signed({p_d0_r[PW-1], p_d0_r}) - $signed({p_d1_r[PW-1], p_d1_r});
    na_nxt  = $signed({p_a0_r[PW-1], p_a0_r}) - $signed({p_a1_r[PW-1], p_a1_r});
    nb_nxt  = $signed({p_b0_r[PW-1], p_b0_r}) - $signed({p_b1_r[PW-1], p_b1_r});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      abx_r  <= abx_nxt;
      aby_r  <= aby_nxt;
      cdx_r  <= cdx_nxt;
      cdy_r  <= cdy_nxt;
      acx_r  <= acx_nxt;
      acy_r  <= acy_nxt;
      // Stage 2: six independent multiplies.
      p_d0_r <= abx_r * cdy_r;
      p_d1_r <= aby_r * cdx_r;
      p_a0_r <= acy_r * cdx_r;
      p_a1_r <= acx_r * cdy_r;
      p_b0_r <= acy_r * abx_r;
      p_b1_r <= acx_r * aby_r;
      den_r  <= den_nxt;
      na_r   <= na_nxt;
      nb_r   <= nb_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  assign out_valid = v3_r;
  assign den       = den_r;
  assign num_a     = na_r;
  assign num_b     = nb_r;

endmodule

/* rtl/sip_qual.sv */
`timescale 1ns / 1ps
// Sign normalization and hit qualification of the cross products.
// Depends on sip_pkg.
module sip_qual #(
  parameter int SUM_BITS = 2 * sip_pkg::COORD_BITS_DEF + 3
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              en,
  input  logic                              in_valid,
  input  logic signed [SUM_BITS-1:0]        den,
  input  logic signed [SUM_BITS-1:0]        num_a,
  input  logic signed [SUM_BITS-1:0]        num_b,
  input  logic [sip_pkg::MIN_DEN_BITS-1:0]  min_den,
  output sip_pkg::sip_ctl_t                 out_ctl,
  output logic [SUM_BITS-1:0]               out_den,
  output logic [SUM_BITS-1:0]               out_num_a,
  output logic [SUM_BITS-1:0]               out_num_b
);
  import sip_pkg::*;

  localparam int CW = (SUM_BITS > MIN_DEN_BITS) ? SUM_BITS : MIN_DEN_BITS;

  logic signed [SUM_BITS-1:0] den_abs_r, na_r, nb_r;
  logic signed [SUM_BITS-1:0] den_abs_nxt, na_nxt, nb_nxt;
  logic [SUM_BITS-1:0]        den_q_r, na_q_r, nb_q_r;
  logic                       v4_r;
  sip_ctl_t                   ctl_r, ctl_nxt;
  logic [MIN_DEN_BITS-1:0]    min_eff;

  // Stage 4: flip all three when the denominator is negative.
  always_comb begin
    if (den[SUM_BITS-1]) begin
      den_abs_nxt = -den;
      na_nxt      = -num_a;
      nb_nxt      = -num_b;
    end else begin
      den_abs_nxt = den;
      na_nxt      = num_a;
      nb_nxt      = num_b;
    end
  end

  // Stage 5: a zero minimum behaves as one, so parallel segments always miss.
  always_comb begin
    min_eff = (min_den == '0) ? MIN_DEN_BITS'(1) : min_den;
    ctl_nxt.valid = v4_r;
    ctl_nxt.hit   = (CW'($unsigned(den_abs_r)) >= CW'(min_eff)) &&
                    !na_r[SUM_BITS-1] && (na_r <= den_abs_r) &&
                    !nb_r[SUM_BITS-1] && (nb_r <= den_abs_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_abs_r <= den_abs_nxt;
      na_r      <= na_nxt;
      nb_r      <= nb_nxt;
      den_q_r   <= $unsigned(den_abs_r);
      na_q_r    <= $unsigned(na_r);
      nb_q_r    <= $unsigned(nb_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r  <= 1'b0;
      ctl_r <= '0;
    end else if (en) begin
      v4_r  <= in_valid;
      ctl_r <= ctl_nxt;
    end
  end

  assign out_ctl   = ctl_r;
  assign out_den   = den_q_r;
  assign out_num_a = na_q_r;
  assign out_num_b = nb_q_r;

endmodule

/* rtl/sip_div.sv */
`timescale 1ns / 1ps
// Pipelined restoring fraction divider, two numerators over one denominator.
// One quotient bit per stage. Depends on sip_pkg.
module sip_div #(
  parameter int WIDTH     = 2 * sip_pkg::COORD_BITS_DEF + 3,
  parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  sip_pkg::sip_ctl_t     in_ctl,
  input  logic [WIDTH-1:0]      den,
  input  logic [WIDTH-1:0]      num_a,
  input  logic [WIDTH-1:0]      num_b,
  output sip_pkg::sip_ctl_t     out_ctl,
  output logic [FRAC_BITS:0]    quo_a,
  output logic [FRAC_BITS:0]    quo_b
);
  import sip_pkg::*;

  localparam int NS = FRAC_BITS + 1;  // quotient bits, one stage each
  localparam int RW = WIDTH + 1;      // remainder may reach twice the divisor

  logic [RW-1:0]    ra_r [NS];
  logic [RW-1:0]    rb_r [NS];
  logic [WIDTH-1:0] d_r  [NS];
  logic [NS-1:0]    qa_r [NS];
  logic [NS-1:0]    qb_r [NS];
  sip_ctl_t         ctl_r [NS];

  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic [RW-1:0]    ra_in, rb_in, ta, tb, ra_nxt, rb_nxt;
    logic [WIDTH-1:0] d_in;
    logic [NS-1:0]    qa_in, qb_in;
    sip_ctl_t         ctl_in;
    logic             bit_a, bit_b;

    if (i == 0) begin : g_first
      assign ra_in  = RW'(num_a);
      assign rb_in  = RW'(num_b);
      assign d_in   = den;
      assign qa_in  = '0;
      assign qb_in  = '0;
      assign ctl_in = in_ctl;
      assign ta     = ra_in;
      assign tb     = rb_in;
    end else begin : g_rest
      assign ra_in  = ra_r[i-1];
      assign rb_in  = rb_r[i-1];
      assign d_in   = d_r[i-1];
      assign qa_in  = qa_r[i-1];
      assign qb_in  = qb_r[i-1];
      assign ctl_in = ctl_r[i-1];
      assign ta     = ra_in << 1;
      assign tb     = rb_in << 1;
    end

    // Compare and subtract once per stage.
    always_comb begin
      bit_a  = ta >= RW'(d_in);
      bit_b  = tb >= RW'(d_in);
      ra_nxt = bit_a ? (ta - RW'(d_in)) : ta;
      rb_nxt = bit_b ? (tb - RW'(d_in)) : tb;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ra_r[i] <= ra_nxt;
        rb_r[i] <= rb_nxt;
        d_r[i]  <= d_in;
        qa_r[i] <= {qa_in[NS-2:0], bit_a};
        qb_r[i] <= {qb_in[NS-2:0], bit_b};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i] <= '0;
      end else if (en) begin
        ctl_r[i] <= ctl_in;
      end
    end
  end

  assign out_ctl = ctl_r[NS-1];
  assign quo_a   = qa_r[NS-1];
  assign quo_b   = qb_r[NS-1];

endmodule

/* rtl/sip_out.sv */
`timescale 1ns / 1ps
// Output register with a one-entry skid buffer; zeroes the fractions on a miss.
// Drives the pipeline advance enable. Depends on sip_pkg.
module sip_out #(
  parameter int FRAC_BITS = sip_pkg::FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  sip_pkg::sip_ctl_t  in_ctl,
  input  logic [FRAC_BITS:0] quo_a,
  input  logic [FRAC_BITS:0] quo_b,
  output logic               pipe_en,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_hit,
  output logic [FRAC_BITS:0] out_alpha,
  output logic [FRAC_BITS:0] out_beta
);
  import sip_pkg::*;

  logic               out_valid_r, skid_full_r;
  logic               out_hit_r, skid_hit_r;
  logic [FRAC_BITS:0] out_alpha_r, out_beta_r, skid_alpha_r, skid_beta_r;
  logic [FRAC_BITS:0] alpha_m, beta_m;
  logic               take, push, to_out, to_skid;

  always_comb begin
    alpha_m = in_ctl.hit ? quo_a : '0;
    beta_m  = in_ctl.hit ? quo_b : '0;
    take    = out_valid_r && !out_stall;
    push    = in_ctl.valid && !skid_full_r;
    to_out  = push && (!out_valid_r || take);
    to_skid = push && out_valid_r && !take;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_full_r <= 1'b0;
    end else begin
      if (skid_full_r) begin
        // Drain the skid entry into the output register once taken.
        if (take) begin
          skid_full_r <= 1'b0;
        end
      end else if (to_out) begin
        out_valid_r <= 1'b1;
      end else if (to_skid) begin
        skid_full_r <= 1'b1;
      end else if (take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full_r) begin
      if (take) begin
        out_hit_r   <= skid_hit_r;
        out_alpha_r <= skid_alpha_r;
        out_beta_r  <= skid_beta_r;
      end
    end else if (to_out) begin
      out_hit_r   <= in_ctl.hit;
      out_alpha_r <= alpha_m;
      out_beta_r  <= beta_m;
    end
    if (to_skid) begin
      skid_hit_r   <= in_ctl.hit;
      skid_alpha_r <= alpha_m;
      skid_beta_r  <= beta_m;
    end
  end

  assign pipe_en   = !skid_full_r;
  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;
  assign out_alpha = out_alpha_r;
  assign out_beta  = out_beta_r;

endmodule
